// File: design/swpr_pkg.sv
// Package for the sync word packet receiver: field structs, kind and status
// codes, body store sizing and the memory request bundle.
// No dependencies; every other file refers to it by scoped names.
package swpr_pkg;

  localparam int RECORD_BYTES = 32;
  localparam int BODY_LEN     = RECORD_BYTES + 4;
  localparam int STORE_DEPTH  = 68;
  localparam int STORE_AW     = $clog2(STORE_DEPTH);

  localparam logic [31:0] SYNC_RESET = 32'hDEADBEEF;

  localparam logic [1:0] KIND_BYTE    = 2'd0;
  localparam logic [1:0] KIND_RELEASE = 2'd1;
  localparam logic [1:0] KIND_READ    = 2'd2;

  localparam logic [2:0] ST_SHIFT    = 3'd0;
  localparam logic [2:0] ST_SYNC     = 3'd1;
  localparam logic [2:0] ST_STORED   = 3'd2;
  localparam logic [2:0] ST_GOOD     = 3'd3;
  localparam logic [2:0] ST_BAD      = 3'd4;
  localparam logic [2:0] ST_REFUSED  = 3'd5;
  localparam logic [2:0] ST_RELEASED = 3'd6;
  localparam logic [2:0] ST_READ     = 3'd7;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] rx_byte;
    logic [5:0] read_offset;
  } swpr_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  packet_type;
    logic [15:0] packet_index;
    logic [7:0]  read_byte;
    logic [15:0] bad_checksum_count;
    logic        packet_held;
  } swpr_out_t;

  // Body store access for one accepted word.
  typedef struct packed {
    logic                we;
    logic [STORE_AW-1:0] waddr;
    logic [7:0]          wdata;
    logic                re;
    logic [STORE_AW-1:0] raddr;
  } swpr_mem_req_t;

  // Result of one word apart from the payload byte read from the store.
  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  packet_type;
    logic [15:0] packet_index;
    logic [15:0] bad_checksum_count;
    logic        packet_held;
    logic        read_sel;
  } swpr_result_t;

endpackage

// File: design/swpr_body_ram.sv
// Body store of the packet receiver: one write port and one read port with
// a registered read. Depends on swpr_pkg for depth and address width.
module swpr_body_ram (
  input  logic                          clk,
  input  logic                          we,
  input  logic [swpr_pkg::STORE_AW-1:0] waddr,
  input  logic [7:0]                    wdata,
  input  logic                          re,
  input  logic [swpr_pkg::STORE_AW-1:0] raddr,
  output logic [7:0]                    rdata
);

  logic [7:0] mem [swpr_pkg::STORE_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Hold the last read while no new read is issued.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: design/swpr_ctrl.sv
// Framing control of the packet receiver: sync window, body counter,
// running checksum, hold flag, reject counter and header shadow registers.
// Depends on swpr_pkg; drives the body store through swpr_mem_req_t.
module swpr_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   accept,
  input  swpr_pkg::swpr_in_t     item,
  input  logic                   cfg_we,
  input  logic [31:0]            cfg_data,
  output swpr_pkg::swpr_mem_req_t mem_req,
  output swpr_pkg::swpr_result_t  result
);

  logic [31:0]                   sync_word;
  logic [31:0]                   sync_window, sync_window_next;
  logic                          collecting, collecting_next;
  logic [swpr_pkg::STORE_AW-1:0] body_count, body_count_next;
  logic [7:0]                    running_sum, running_sum_next;
  logic                          held_flag, held_flag_next;
  logic [15:0]                   rejected_count, rejected_count_next;
  logic [7:0]                    packet_type, packet_type_next;
  logic [15:0]                   packet_index, packet_index_next;
  logic [2:0]                    status;

  always_comb begin
    sync_window_next    = sync_window;
    collecting_next     = collecting;
    body_count_next     = body_count;
    running_sum_next    = running_sum;
    held_flag_next      = held_flag;
    rejected_count_next = rejected_count;
    status              = swpr_pkg::ST_SHIFT;
    mem_req.we          = 1'b0;
    mem_req.waddr       = body_count;
    mem_req.wdata       = item.rx_byte;
    mem_req.re          = 1'b0;
    mem_req.raddr       = swpr_pkg::STORE_AW'({1'b0, item.read_offset})
                          + swpr_pkg::STORE_AW'(3);
    case (item.kind)
      swpr_pkg::KIND_BYTE: begin
        if (held_flag) begin
          status = swpr_pkg::ST_REFUSED;
        end else if (!collecting) begin
          sync_window_next = {item.rx_byte, sync_window[31:8]};
          if (sync_window_next == sync_word) begin
            collecting_next  = 1'b1;
            body_count_next  = '0;
            running_sum_next = '0;
            status           = swpr_pkg::ST_SYNC;
          end
        end else begin
          mem_req.we = accept;
          if (body_count == swpr_pkg::STORE_AW'(swpr_pkg::BODY_LEN - 1)) begin
            collecting_next = 1'b0;
            body_count_next = '0;
            if (item.rx_byte == running_sum) begin
              held_flag_next = 1'b1;
              status         = swpr_pkg::ST_GOOD;
            end else begin
              rejected_count_next = rejected_count + 16'd1;
              status              = swpr_pkg::ST_BAD;
            end
          end else begin
            body_count_next  = body_count + swpr_pkg::STORE_AW'(1);
            running_sum_next = running_sum + item.rx_byte;
            status           = swpr_pkg::ST_STORED;
          end
        end
      end
      swpr_pkg::KIND_RELEASE: begin
        held_flag_next = 1'b0;
        status         = swpr_pkg::ST_RELEASED;
      end
      swpr_pkg::KIND_READ: begin
        status     = swpr_pkg::ST_READ;
        mem_req.re = accept &&
                     ({1'b0, item.read_offset} < 7'(swpr_pkg::RECORD_BYTES));
      end
      default: begin
        status = swpr_pkg::ST_SHIFT;
      end
    endcase
  end

  // Shadow the header bytes so they are visible on every result.
  always_comb begin
    packet_type_next  = packet_type;
    packet_index_next = packet_index;
    if (mem_req.we) begin
      if (body_count == swpr_pkg::STORE_AW'(0)) begin
        packet_type_next = item.rx_byte;
      end
      if (body_count == swpr_pkg::STORE_AW'(1)) begin
        packet_index_next[7:0] = item.rx_byte;
      end
      if (body_count == swpr_pkg::STORE_AW'(2)) begin
        packet_index_next[15:8] = item.rx_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_word      <= swpr_pkg::SYNC_RESET;
      sync_window    <= '0;
      collecting     <= 1'b0;
      body_count     <= '0;
      running_sum    <= '0;
      held_flag      <= 1'b0;
      rejected_count <= '0;
    end else begin
      if (cfg_we) begin
        sync_word <= cfg_data;
      end
      if (accept) begin
        sync_window    <= sync_window_next;
        collecting     <= collecting_next;
        body_count     <= body_count_next;
        running_sum    <= running_sum_next;
        held_flag      <= held_flag_next;
        rejected_count <= rejected_count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      packet_type  <= packet_type_next;
      packet_index <= packet_index_next;
    end
  end

  assign result.status             = status;
  assign result.packet_type        = packet_type_next;
  assign result.packet_index       = packet_index_next;
  assign result.bad_checksum_count = rejected_count_next;
  assign result.packet_held        = held_flag_next;
  assign result.read_sel           = mem_req.re;

endmodule

// File: design/sync_word_packet_receiver_top.sv
// Top level of the sync word packet receiver: framing control, body store
// and the output register. Depends on swpr_pkg, swpr_ctrl and swpr_body_ram.
//
//   channel   signals                       direction
//   input     in_valid in_stall in_data     word in, stall out
//   output    out_valid out_stall out_data  word out, stall in
//   config    cfg_we cfg_data               sync word write
//
// One word per cycle while in_stall is low. A result appears in the
// cycle after its word is taken; the payload byte comes from the body
// store read issued on that edge. in_stall rises only while a result
// waits and out_stall is high. Reset (rst, synchronous) clears the
// framing state and sets the sync word; the body store is not cleared.
module sync_word_packet_receiver_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  swpr_pkg::swpr_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output swpr_pkg::swpr_out_t out_data,
  input  logic                cfg_we,
  input  logic [31:0]         cfg_data
);

  logic                    accept;
  swpr_pkg::swpr_mem_req_t mem_req;
  swpr_pkg::swpr_result_t  result;
  swpr_pkg::swpr_result_t  result_q;
  logic [7:0]              rdata;

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  swpr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .item     (in_data),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .mem_req  (mem_req),
    .result   (result)
  );

  swpr_body_ram u_ram (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .re    (mem_req.re),
    .raddr (mem_req.raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result_q <= result;
    end
  end

  assign out_data.status             = result_q.status;
  assign out_data.packet_type        = result_q.packet_type;
  assign out_data.packet_index       = result_q.packet_index;
  assign out_data.read_byte          = result_q.read_sel ? rdata : 8'd0;
  assign out_data.bad_checksum_count = result_q.bad_checksum_count;
  assign out_data.packet_held        = result_q.packet_held;

endmodule

// File: test/sync_word_packet_receiver_top_tb.sv
// Self-checking testbench for sync_word_packet_receiver_top: drives framed byte
// traffic, release and payload read words, and checks each result against a
// behavioral predictor. Depends on swpr_pkg and the receiver RTL.
module sync_word_packet_receiver_top_tb;

  localparam logic [1:0] KIND_UNUSED = 2'd3;

  typedef struct {
    swpr_pkg::swpr_out_t value;
    swpr_pkg::swpr_out_t care;
  } expected_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  swpr_pkg::swpr_in_t  in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  swpr_pkg::swpr_out_t out_data;
  logic                cfg_we = 1'b0;
  logic [31:0]         cfg_data = '0;

  // Predictor state
  logic [31:0] cur_sync = swpr_pkg::SYNC_RESET;
  logic [31:0] win = '0;
  logic        collecting = 1'b0;
  int          body_pos = 0;
  logic [7:0]  csum = '0;
  logic        holding = 1'b0;
  logic [15:0] reject_cnt = '0;
  logic [7:0]  body_mem [swpr_pkg::STORE_DEPTH];
  logic        body_known [swpr_pkg::STORE_DEPTH];

  expected_t pending_results[$];
  int        mismatch_count = 0;
  int        item_count = 0;
  int        burst_left = 0;
  int        stall_tick = 0;
  int        stall_mode = 0;

  sync_word_packet_receiver_top uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data)
  );

  always #2 clk = ~clk;

  // Receiver stall pattern: switch between no stall, light, heavy and bursty stalls.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      stall_tick <= stall_tick + 1;
      if (stall_tick % 64 == 0) begin
        stall_mode <= $urandom_range(0, 3);
      end
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ($urandom_range(0, 9) < 7);
        default: out_stall <= ((stall_tick % 16) < 10);
      endcase
    end
  end

  function automatic logic [2:0] absorb_byte(input logic [7:0] b);
    if (holding) return swpr_pkg::ST_REFUSED;
    if (!collecting) begin
      win = {b, win[31:8]};
      if (win == cur_sync) begin
        collecting = 1'b1;
        body_pos = 0;
        csum = '0;
        return swpr_pkg::ST_SYNC;
      end
      return swpr_pkg::ST_SHIFT;
    end
    // body bytes bypass the window
    body_mem[body_pos] = b;
    body_known[body_pos] = 1'b1;
    body_pos++;
    if (body_pos >= swpr_pkg::BODY_LEN) begin
      collecting = 1'b0;
      body_pos = 0;
      if (b == csum) begin
        holding = 1'b1;
        return swpr_pkg::ST_GOOD;
      end
      reject_cnt = reject_cnt + 16'd1;
      return swpr_pkg::ST_BAD;
    end
    csum = csum + b;
    return swpr_pkg::ST_STORED;
  endfunction

  function automatic void predict_word(input swpr_pkg::swpr_in_t w);
    expected_t e;
    e.value = '0;
    e.care = '1;
    case (w.kind)
      swpr_pkg::KIND_BYTE: e.value.status = absorb_byte(w.rx_byte);
      swpr_pkg::KIND_RELEASE: begin
        holding = 1'b0;
        e.value.status = swpr_pkg::ST_RELEASED;
      end
      swpr_pkg::KIND_READ: begin
        if (w.read_offset < swpr_pkg::RECORD_BYTES) begin
          e.value.read_byte = body_mem[w.read_offset + 3];
        end
        e.value.status = swpr_pkg::ST_READ;
      end
      default: e.value.status = swpr_pkg::ST_SHIFT;
    endcase
    // type and index bytes are undefined until first stored
    e.value.packet_type = body_mem[0];
    e.care.packet_type = body_known[0] ? 8'hFF : 8'h00;
    e.value.packet_index = {body_mem[2], body_mem[1]};
    e.care.packet_index = {body_known[2] ? 8'hFF : 8'h00, body_known[1] ? 8'hFF : 8'h00};
    e.value.bad_checksum_count = reject_cnt;
    e.value.packet_held = holding;
    pending_results.push_back(e);
  endfunction

  task automatic compare_field(input string name, input logic [15:0] got,
                               input logic [15:0] exp, input logic [15:0] care);
    if (((got ^ exp) & care) !== 16'h0) begin
      mismatch_count++;
      if (mismatch_count <= 10) begin
        $display("mismatch on %s: expected %h, got %h", name, exp & care, got);
      end
    end
  endtask

  always @(posedge clk) begin : check_results
    expected_t e;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected result word %h", out_data);
      end else begin
        e = pending_results.pop_front();
        compare_field("status", 16'(out_data.status), 16'(e.value.status),
                      16'(e.care.status));
        compare_field("packet_type", 16'(out_data.packet_type),
                      16'(e.value.packet_type), 16'(e.care.packet_type));
        compare_field("packet_index", out_data.packet_index, e.value.packet_index,
                      e.care.packet_index);
        compare_field("read_byte", 16'(out_data.read_byte), 16'(e.value.read_byte),
                      16'(e.care.read_byte));
        compare_field("bad_checksum_count", out_data.bad_checksum_count,
                      e.value.bad_checksum_count, e.care.bad_checksum_count);
        compare_field("packet_held", 16'(out_data.packet_held),
                      16'(e.value.packet_held), 16'(e.care.packet_held));
      end
    end
  end

  function automatic swpr_pkg::swpr_in_t mk_item(input logic [1:0] kind,
                                                 input logic [7:0] rx,
                                                 input logic [5:0] off);
    swpr_pkg::swpr_in_t w;
    w.kind = kind;
    w.rx_byte = rx;
    w.read_offset = off;
    return w;
  endfunction

  // Never point a read at a payload entry that was not written yet.
  function automatic logic [5:0] pick_offset();
    int off;
    off = $urandom_range(0, 63);
    if (off < swpr_pkg::RECORD_BYTES && !body_known[off + 3]) begin
      off = $urandom_range(swpr_pkg::RECORD_BYTES, 63);
    end
    return off[5:0];
  endfunction

  function automatic swpr_pkg::swpr_in_t random_item(input int lowest_kind);
    logic [1:0] kind;
    kind = 2'($urandom_range(lowest_kind, 3));
    return mk_item(kind, 8'($urandom),
                   (kind == swpr_pkg::KIND_READ) ? pick_offset() : 6'($urandom));
  endfunction

  task automatic send_word(input swpr_pkg::swpr_in_t w);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (in_stall);
    predict_word(w);
    if (w.kind != KIND_UNUSED) item_count++;
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_word(mk_item(swpr_pkg::KIND_BYTE, b, 6'($urandom)));
  endtask

  task automatic send_release();
    send_word(mk_item(swpr_pkg::KIND_RELEASE, 8'($urandom), 6'($urandom)));
  endtask

  task automatic send_read(input logic [5:0] off);
    send_word(mk_item(swpr_pkg::KIND_READ, 8'($urandom), off));
  endtask

  // Hold off the sender until every result is back.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic program_sync(input logic [31:0] value);
    wait_for_results();
    cfg_we <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_sync = value;
  endtask

  // Finish any open body and release any held packet.
  task automatic settle_receiver();
    while (collecting) send_byte(8'($urandom));
    if (holding) send_release();
  endtask

  // Stop early when a self-overlapping sync word matches before its last byte.
  task automatic send_sync();
    for (int i = 0; i < 4; i++) begin
      send_byte(cur_sync[8*i +: 8]);
      if (collecting) break;
    end
  endtask

  task automatic send_packet(input bit good, input bit chatter, input int fill);
    logic [7:0] body [swpr_pkg::BODY_LEN];
    logic [7:0] sum;
    sum = '0;
    for (int i = 0; i < swpr_pkg::BODY_LEN - 1; i++) begin
      case (fill)
        0: body[i] = 8'($urandom);
        1: body[i] = 8'h00;
        2: body[i] = 8'hFF;
        default: body[i] = cur_sync[8*(i % 4) +: 8];
      endcase
      sum = sum + body[i];
    end
    body[swpr_pkg::BODY_LEN-1] = good ? sum : sum + 8'($urandom_range(1, 255));
    settle_receiver();
    send_sync();
    for (int i = 0; i < swpr_pkg::BODY_LEN; i++) begin
      if (chatter && $urandom_range(0, 5) == 0) send_word(random_item(1));
      send_byte(body[i]);
    end
  endtask

  task automatic test_directed_items();
    send_word(mk_item(KIND_UNUSED, 8'hFF, 6'h3F));
    send_word(mk_item(KIND_UNUSED, 8'h00, 6'h00));
    send_word(mk_item(swpr_pkg::KIND_RELEASE, 8'hA5, 6'h15));
    send_read(6'd32);
    send_read(6'd63);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h80);
    send_byte(8'h01);
    // partial sync followed by a wrong byte
    send_byte(cur_sync[7:0]);
    send_byte(cur_sync[15:8]);
    send_byte(cur_sync[23:16]);
    send_byte(~cur_sync[31:24]);
  endtask

  task automatic test_framing();
    // sync pattern inside the payload must not restart framing
    send_packet(1'b1, 1'b0, 3);
    repeat (3) send_byte(8'($urandom));
    for (int i = 0; i < 64; i++) send_read(i[5:0]);
    send_release();
    send_release();
    send_packet(1'b0, 1'b0, 2);
    send_packet(1'b1, 1'b1, 1);
    send_packet(1'b1, 1'b1, 0);
    send_release();
  endtask

  task automatic test_sync_words();
    logic [31:0] words [4];
    words[0] = 32'h0000_0000;
    words[1] = 32'hFFFF_FFFF;
    words[2] = $urandom;
    words[3] = swpr_pkg::SYNC_RESET;
    for (int k = 0; k < 4; k++) begin
      program_sync(words[k]);
      send_packet(1'b1, 1'b0, $urandom_range(0, 3));
      send_packet(1'b0, 1'b1, $urandom_range(0, 3));
      // window keeps the sync word after a reject, so repeated-byte words rematch at once
      send_byte(words[k][31:24]);
      send_packet(1'b1, 1'b1, 0);
      send_release();
    end
  endtask

  task automatic test_random_traffic();
    int start;
    int r;
    for (int phase = 0; phase < 2; phase++) begin
      program_sync(phase == 0 ? 32'($urandom) : swpr_pkg::SYNC_RESET);
      start = item_count;
      while (item_count - start < 360) begin
        r = $urandom_range(0, 19);
        if (r < 13) begin
          send_packet($urandom_range(0, 4) != 0, $urandom_range(0, 2) == 0,
                      ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0);
          if (holding) begin
            repeat ($urandom_range(0, 3)) send_byte(8'($urandom));
            repeat ($urandom_range(0, 4)) send_read(pick_offset());
            if ($urandom_range(0, 4) != 0) send_release();
          end
        end else if (r < 16) begin
          repeat ($urandom_range(1, 12)) send_word(random_item(0));
        end else if (r < 18) begin
          // truncated body; the next words complete it
          settle_receiver();
          send_sync();
          repeat ($urandom_range(0, swpr_pkg::BODY_LEN - 1)) send_byte(8'($urandom));
        end else if (r == 18) begin
          settle_receiver();
          for (int i = 0; i < $urandom_range(1, 3); i++) send_byte(cur_sync[8*i +: 8]);
          send_byte(8'($urandom));
        end else begin
          wait_for_results();
        end
      end
    end
  endtask

  initial begin
    for (int i = 0; i < swpr_pkg::STORE_DEPTH; i++) begin
      body_mem[i] = '0;
      body_known[i] = 1'b0;
    end
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_directed_items();
    test_framing();
    test_sync_words();
    test_random_traffic();
    wait_for_results();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("Verification failed");
    $finish;
  end

endmodule

// File: filelist.f
design/swpr_pkg.sv
design/swpr_body_ram.sv
design/swpr_ctrl.sv
design/sync_word_packet_receiver_top.sv
test/sync_word_packet_receiver_top_tb.sv
